>>> sv/apik_pkg.sv
// shared constants and tables for the arm position inverse kinematics unit
package apik_pkg;

  // register indexes on the configuration channel
  localparam logic [7:0] REG_BASE_HEIGHT = 8'd0;
  localparam logic [7:0] REG_UPPER_ARM   = 8'd1;
  localparam logic [7:0] REG_FOREARM     = 8'd2;
  localparam logic [7:0] REG_WRIST       = 8'd3;

  localparam logic [15:0] RST_BASE_HEIGHT = 16'd21824;
  localparam logic [15:0] RST_UPPER_ARM   = 16'd20709;
  localparam logic [15:0] RST_FOREARM     = 16'd25166;
  localparam logic [15:0] RST_WRIST       = 16'd7012;

  localparam int REACH_MIN  = 6554;
  localparam int REACH_TRIM = 655;
  localparam int ONE_Q16    = 65536;

  // angles in Q24 radians
  localparam int ANG_W = 28;
  localparam logic signed [ANG_W-1:0] Q24_PI      = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] Q24_HALF_PI = 28'sd26353589;

  localparam int CORDIC_STEPS = 24;
  localparam logic [25:0] ATAN_TAB [CORDIC_STEPS] = '{
    26'd13176795, 26'd7778716, 26'd4110060, 26'd2086331, 26'd1047214, 26'd524117,
    26'd262123, 26'd131069, 26'd65536, 26'd32768, 26'd16384, 26'd8192,
    26'd4096, 26'd2048, 26'd1024, 26'd512, 26'd256, 26'd128,
    26'd64, 26'd32, 26'd16, 26'd8, 26'd4, 26'd2
  };

endpackage

>>> sv/apik_sqrt.sv
// pipelined integer square root, one result bit per stage
module apik_sqrt #(
  parameter int W  = 40,
  parameter int TW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  logic [W-1:0]     rad,
  input  logic [TW-1:0]    tag_in,
  output logic             vld_out,
  output logic [W/2-1:0]   root,
  output logic [TW-1:0]    tag_out
);

  localparam int K = W / 2;

  logic [W-1:0]  rem [K+1];
  logic [W-1:0]  res [K+1];
  logic          vld [K+1];
  logic [TW-1:0] tg  [K+1];

  assign rem[0] = rad;
  assign res[0] = '0;
  assign vld[0] = vld_in;
  assign tg[0]  = tag_in;

  for (genvar k = 0; k < K; k++) begin : g_stage
    localparam logic [W:0] BIT = (W+1)'(1) << (2 * (K - 1 - k));
    logic [W:0] trial;
    assign trial = {1'b0, res[k]} + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      tg[k+1] <= tg[k];
      if ({1'b0, rem[k]} >= trial) begin
        rem[k+1] <= W'({1'b0, rem[k]} - trial);
        res[k+1] <= W'(({1'b0, res[k]} >> 1) + BIT);
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k] >> 1;
      end
    end
  end

  assign vld_out = vld[K];
  assign root    = res[K][K-1:0];
  assign tag_out = tg[K];

endmodule

>>> sv/apik_div.sv
// pipelined restoring divider with an overflow check ahead of the quotient bits
module apik_div #(
  parameter int DW = 51,
  parameter int SW = 33,
  parameter int QW = 17,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  logic [DW-1:0] dvd,
  input  logic [SW-1:0] dvs,
  input  logic [TW-1:0] tag_in,
  output logic          vld_out,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [TW-1:0] tag_out
);

  logic [DW-1:0] rem [QW+1];
  logic [SW-1:0] dv  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic          of  [QW+1];
  logic          vld [QW+1];
  logic [TW-1:0] tg  [QW+1];

  logic [DW-1:0] dvs_ext;
  assign dvs_ext = {{(DW-SW){1'b0}}, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= vld_in;
    end
  end

  // input register, flagging a quotient too wide for QW bits
  always_ff @(posedge clk) begin
    rem[0] <= dvd;
    dv[0]  <= dvs;
    q[0]   <= '0;
    of[0]  <= dvd >= (dvs_ext << QW);
    tg[0]  <= tag_in;
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int B = QW - 1 - j;
    logic [DW-1:0] trial;
    assign trial = {{(DW-SW){1'b0}}, dv[j]} << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      dv[j+1] <= dv[j];
      of[j+1] <= of[j];
      tg[j+1] <= tg[j];
      if (!of[j] && rem[j] >= trial) begin
        rem[j+1] <= rem[j] - trial;
        q[j+1]   <= q[j] | (QW'(1) << B);
      end else begin
        rem[j+1] <= rem[j];
        q[j+1]   <= q[j];
      end
    end
  end

  assign vld_out = vld[QW];
  assign quo     = q[QW];
  assign ovf     = of[QW];
  assign tag_out = tg[QW];

endmodule

>>> sv/apik_atan.sv
// pipelined atan2: fold, normalize, vectoring cordic, unfold
module apik_atan #(
  parameter int W = 36
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vld_in,
  input  logic signed [W-1:0]                yin,
  input  logic signed [W-1:0]                xin,
  output logic                               vld_out,
  output logic signed [apik_pkg::ANG_W-1:0]  ang
);

  localparam int MW = 40;
  localparam int CW = 44;
  localparam int NS = 6;
  localparam int ST = apik_pkg::CORDIC_STEPS;
  localparam int ZW = apik_pkg::ANG_W;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic xz;
    logic yz;
    logic zz;
  } flags_t;

  logic [W:0] xa, ya;
  assign xa = xin[W-1] ? (~{xin[W-1], xin} + 1'b1) : {xin[W-1], xin};
  assign ya = yin[W-1] ? (~{yin[W-1], yin} + 1'b1) : {yin[W-1], yin};

  logic [MW-1:0] nx  [NS+1];
  logic [MW-1:0] ny  [NS+1];
  flags_t        nf  [NS+1];
  logic          nv  [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
    end else begin
      nv[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    nx[0]      <= MW'(xa);
    ny[0]      <= MW'(ya);
    nf[0].xneg <= xin[W-1];
    nf[0].yneg <= yin[W-1];
    nf[0].xz   <= (xa == '0);
    nf[0].yz   <= (ya == '0);
    nf[0].zz   <= (xa == '0) && (ya == '0);
  end

  // shift left until the larger operand has its top bit set
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int S = 1 << (NS - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        nv[k+1] <= 1'b0;
      end else begin
        nv[k+1] <= nv[k];
      end
    end
    always_ff @(posedge clk) begin
      nf[k+1] <= nf[k];
      if (((nx[k] | ny[k]) >> (MW - S)) == '0) begin
        nx[k+1] <= nx[k] << S;
        ny[k+1] <= ny[k] << S;
      end else begin
        nx[k+1] <= nx[k];
        ny[k+1] <= ny[k];
      end
    end
  end

  logic signed [CW-1:0] cx [ST+1];
  logic signed [CW-1:0] cy [ST+1];
  logic signed [ZW-1:0] cz [ST+1];
  flags_t               cf [ST+1];
  logic                 cv [ST+1];

  assign cx[0] = $signed({{(CW-MW){1'b0}}, nx[NS]});
  assign cy[0] = $signed({{(CW-MW){1'b0}}, ny[NS]});
  assign cz[0] = '0;
  assign cf[0] = nf[NS];
  assign cv[0] = nv[NS];

  for (genvar i = 0; i < ST; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ANG = $signed({2'b00, apik_pkg::ATAN_TAB[i]});
    logic signed [CW-1:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      cf[i+1] <= cf[i];
      if (!cy[i][CW-1]) begin
        cx[i+1] <= cx[i] + dx;
        cy[i+1] <= cy[i] - dy;
        cz[i+1] <= cz[i] + ANG;
      end else begin
        cx[i+1] <= cx[i] - dx;
        cy[i+1] <= cy[i] + dy;
        cz[i+1] <= cz[i] - ANG;
      end
    end
  end

  logic signed [ZW-1:0] zc, m, mo;
  flags_t               ff;

  always_comb begin
    ff = cf[ST];
    if (cz[ST] < 0) begin
      zc = '0;
    end else if (cz[ST] > apik_pkg::Q24_HALF_PI) begin
      zc = apik_pkg::Q24_HALF_PI;
    end else begin
      zc = cz[ST];
    end
    if (ff.yz) begin
      m = '0;
    end else if (ff.xz) begin
      m = apik_pkg::Q24_HALF_PI;
    end else begin
      m = zc;
    end
    if (ff.xneg) begin
      m = apik_pkg::Q24_PI - m;
    end
    mo = ff.yneg ? -m : m;
    if (ff.zz) begin
      mo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= cv[ST];
    end
  end

  always_ff @(posedge clk) begin
    ang <= mo;
  end

endmodule

>>> sv/arm_position_inverse_kinematics_unit.sv
// top level: target position to base, shoulder and elbow angles
//
//   channel   handshake              payload
//   target    start / busy           target_x, target_y, target_z
//   angles    done (one-cycle pulse) base_angle, shoulder_angle, elbow_angle
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one target per clock; the two 20- and 17-stage square roots, the 18-stage
// divider and the 32-stage atan2 units sit in series from start to done, with
// the glue stages between them
// busy and cfg_ready are constant, nothing inside ever stalls
// synchronous reset clears the valid pipeline and loads the default link lengths
module arm_position_inverse_kinematics_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [18:0] target_x,
  input  logic signed [18:0] target_y,
  input  logic signed [18:0] target_z,
  output logic               done,
  output logic signed [18:0] base_angle,
  output logic signed [19:0] shoulder_angle,
  output logic signed [18:0] elbow_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = apik_pkg::ANG_W;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [15:0] bh, ua, fa, wo;

  always_ff @(posedge clk) begin
    if (rst) begin
      bh <= apik_pkg::RST_BASE_HEIGHT;
      ua <= apik_pkg::RST_UPPER_ARM;
      fa <= apik_pkg::RST_FOREARM;
      wo <= apik_pkg::RST_WRIST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        apik_pkg::REG_BASE_HEIGHT: bh <= cfg_data;
        apik_pkg::REG_UPPER_ARM:   ua <= cfg_data;
        apik_pkg::REG_FOREARM:     fa <= cfg_data;
        apik_pkg::REG_WRIST:       wo <= cfg_data;
        default: ;
      endcase
    end
  end

  // p0: capture
  logic               v0;
  logic signed [18:0] x0, y0, z0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end
  always_ff @(posedge clk) begin
    x0 <= target_x;
    y0 <= target_y;
    z0 <= target_z;
  end

  // p1: squares of x and y, height above shoulder
  logic               v1;
  logic signed [18:0] x1, y1;
  logic signed [19:0] h1;
  logic [36:0]        x2_1, y2_1;
  logic signed [37:0] px, py;
  assign px = x0 * x0;
  assign py = y0 * y0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    x1   <= x0;
    y1   <= y0;
    h1   <= {z0[18], z0} - {4'b0, bh};
    x2_1 <= px[36:0];
    y2_1 <= py[36:0];
  end

  // p2
  logic               v2;
  logic signed [18:0] x2, y2;
  logic signed [19:0] h2;
  logic [36:0]        hh2;
  logic [37:0]        r2_2;
  logic signed [39:0] ph;
  assign ph = h1 * h1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    x2   <= x1;
    y2   <= y1;
    h2   <= h1;
    hh2  <= ph[36:0];
    r2_2 <= {1'b0, x2_1} + {1'b0, y2_1};
  end

  // p3
  logic               v3;
  logic signed [18:0] x3, y3;
  logic signed [19:0] h3;
  logic [37:0]        r2_3;
  logic [38:0]        d2_3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    x3   <= x2;
    y3   <= y2;
    h3   <= h2;
    r2_3 <= r2_2;
    d2_3 <= {1'b0, r2_2} + {2'b0, hh2};
  end

  // planar reach and full distance
  logic        sqa_v, sqb_v;
  logic [19:0] r_sq, dist_sq;
  logic [37:0] sqa_tag;
  logic [19:0] sqb_tag;

  apik_sqrt #(.W(40), .TW(38)) u_sqrt_r (
    .clk    (clk),
    .rst    (rst),
    .vld_in (v3),
    .rad    ({2'b0, r2_3}),
    .tag_in ({x3, y3}),
    .vld_out(sqa_v),
    .root   (r_sq),
    .tag_out(sqa_tag)
  );

  apik_sqrt #(.W(40), .TW(20)) u_sqrt_d (
    .clk    (clk),
    .rst    (rst),
    .vld_in (v3),
    .rad    ({1'b0, d2_3}),
    .tag_in (h3),
    .vld_out(sqb_v),
    .root   (dist_sq),
    .tag_out(sqb_tag)
  );

  // p4: clamp reach to the usable span
  logic               v4;
  logic signed [18:0] x4, y4;
  logic signed [19:0] h4;
  logic [19:0]        r4;
  logic [16:0]        d4;
  logic signed [20:0] ds;
  logic signed [17:0] hi_raw, hi_c;
  assign ds     = $signed({1'b0, dist_sq}) - $signed({5'b0, wo});
  assign hi_raw = $signed({2'b0, ua}) + $signed({2'b0, fa}) - 18'(apik_pkg::REACH_TRIM);
  assign hi_c   = (hi_raw < apik_pkg::REACH_MIN) ? 18'(apik_pkg::REACH_MIN) : hi_raw;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= sqa_v && sqb_v;
    end
  end
  always_ff @(posedge clk) begin
    x4 <= sqa_tag[37:19];
    y4 <= sqa_tag[18:0];
    h4 <= sqb_tag;
    r4 <= r_sq;
    if (ds < apik_pkg::REACH_MIN) begin
      d4 <= 17'(apik_pkg::REACH_MIN);
    end else if (ds > hi_c) begin
      d4 <= hi_c[16:0];
    end else begin
      d4 <= ds[16:0];
    end
  end

  // p5: law of cosines products
  logic               v5;
  logic signed [18:0] x5, y5;
  logic signed [19:0] h5;
  logic [19:0]        r5;
  logic [33:0]        dd5;
  logic [31:0]        uu5, ff5, uf5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    x5  <= x4;
    y5  <= y4;
    h5  <= h4;
    r5  <= r4;
    dd5 <= d4 * d4;
    uu5 <= ua * ua;
    ff5 <= fa * fa;
    uf5 <= ua * fa;
  end

  // p6
  logic               v6;
  logic signed [18:0] x6, y6;
  logic signed [19:0] h6;
  logic [19:0]        r6;
  logic signed [35:0] num6;
  logic [31:0]        uf6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    x6   <= x5;
    y6   <= y5;
    h6   <= h5;
    r6   <= r5;
    num6 <= $signed({2'b0, dd5}) - $signed({4'b0, uu5}) - $signed({4'b0, ff5});
    uf6  <= uf5;
  end

  // p7: magnitude plus half the divisor for round to nearest
  logic               v7;
  logic signed [18:0] x7, y7;
  logic signed [19:0] h7;
  logic [19:0]        r7;
  logic [50:0]        dvd7;
  logic [32:0]        dvs7;
  logic               neg7;
  logic signed [35:0] nabs;
  assign nabs = num6[35] ? -num6 : num6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end
  always_ff @(posedge clk) begin
    x7   <= x6;
    y7   <= y6;
    h7   <= h6;
    r7   <= r6;
    dvd7 <= {1'b0, nabs[33:0], 16'b0} + {19'b0, uf6};
    dvs7 <= {uf6, 1'b0};
    neg7 <= num6[35];
  end

  logic        dv_v, dv_ovf;
  logic [16:0] dv_q;
  logic [78:0] dv_tag;

  apik_div #(.DW(51), .SW(33), .QW(17), .TW(79)) u_div (
    .clk    (clk),
    .rst    (rst),
    .vld_in (v7),
    .dvd    (dvd7),
    .dvs    (dvs7),
    .tag_in ({x7, y7, h7, r7, neg7}),
    .vld_out(dv_v),
    .quo    (dv_q),
    .ovf    (dv_ovf),
    .tag_out(dv_tag)
  );

  // p8: cosine, clamped to one
  logic               v8;
  logic signed [18:0] x8, y8;
  logic signed [19:0] h8;
  logic [19:0]        r8;
  logic signed [17:0] c8;
  logic [16:0]        qc;
  assign qc = (dv_ovf || dv_q > apik_pkg::ONE_Q16) ? 17'(apik_pkg::ONE_Q16) : dv_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= dv_v;
    end
  end
  always_ff @(posedge clk) begin
    x8 <= dv_tag[78:60];
    y8 <= dv_tag[59:41];
    h8 <= dv_tag[40:21];
    r8 <= dv_tag[20:1];
    c8 <= dv_tag[0] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

  // p9
  logic               v9;
  logic signed [18:0] x9, y9;
  logic signed [19:0] h9;
  logic [19:0]        r9;
  logic signed [17:0] c9;
  logic [32:0]        cc9;
  logic signed [35:0] pc;
  assign pc = c8 * c8;
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end
  always_ff @(posedge clk) begin
    x9  <= x8;
    y9  <= y8;
    h9  <= h8;
    r9  <= r8;
    c9  <= c8;
    cc9 <= pc[32:0];
  end

  // p10: one minus cosine squared
  logic               v10;
  logic signed [18:0] x10, y10;
  logic signed [19:0] h10;
  logic [19:0]        r10;
  logic signed [17:0] c10;
  logic [32:0]        t10;
  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
  end
  always_ff @(posedge clk) begin
    x10 <= x9;
    y10 <= y9;
    h10 <= h9;
    r10 <= r9;
    c10 <= c9;
    t10 <= 33'h1_0000_0000 - cc9;
  end

  logic        sqs_v;
  logic [16:0] s_sq;
  logic [95:0] sqs_tag;

  apik_sqrt #(.W(34), .TW(96)) u_sqrt_s (
    .clk    (clk),
    .rst    (rst),
    .vld_in (v10),
    .rad    ({1'b0, t10}),
    .tag_in ({x10, y10, h10, r10, c10}),
    .vld_out(sqs_v),
    .root   (s_sq),
    .tag_out(sqs_tag)
  );

  // p11: elbow correction products
  logic               v11;
  logic signed [18:0] x11, y11;
  logic signed [19:0] h11;
  logic [19:0]        r11;
  logic signed [17:0] c11;
  logic [16:0]        s11;
  logic [32:0]        fs11;
  logic signed [34:0] fc11;
  logic signed [17:0] c_t;
  logic signed [34:0] pfc;
  assign c_t = sqs_tag[17:0];
  assign pfc = $signed({1'b0, fa}) * c_t;
  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= sqs_v;
    end
  end
  always_ff @(posedge clk) begin
    x11  <= sqs_tag[95:77];
    y11  <= sqs_tag[76:58];
    h11  <= sqs_tag[57:38];
    r11  <= sqs_tag[37:18];
    c11  <= c_t;
    s11  <= s_sq;
    fs11 <= fa * s_sq;
    fc11 <= pfc;
  end

  // p12
  logic               v12;
  logic signed [18:0] x12, y12;
  logic signed [19:0] h12;
  logic [19:0]        r12;
  logic signed [17:0] c12;
  logic [16:0]        s12;
  logic [32:0]        fs12;
  logic signed [34:0] w12;
  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
  end
  always_ff @(posedge clk) begin
    x12  <= x11;
    y12  <= y11;
    h12  <= h11;
    r12  <= r11;
    c12  <= c11;
    s12  <= s11;
    fs12 <= fs11;
    w12  <= $signed({3'b0, ua, 16'b0}) - fc11;
  end

  // four angles in parallel
  logic                 av [4];
  logic signed [AW-1:0] aa [4];

  apik_atan #(.W(36)) u_atan_acos (
    .clk(clk), .rst(rst), .vld_in(v12),
    .yin({19'b0, s12}), .xin({{18{c12[17]}}, c12}),
    .vld_out(av[0]), .ang(aa[0])
  );

  apik_atan #(.W(36)) u_atan_corr (
    .clk(clk), .rst(rst), .vld_in(v12),
    .yin({3'b0, fs12}), .xin({w12[34], w12}),
    .vld_out(av[1]), .ang(aa[1])
  );

  apik_atan #(.W(36)) u_atan_elev (
    .clk(clk), .rst(rst), .vld_in(v12),
    .yin({{16{h12[19]}}, h12}), .xin({16'b0, r12}),
    .vld_out(av[2]), .ang(aa[2])
  );

  apik_atan #(.W(36)) u_atan_base (
    .clk(clk), .rst(rst), .vld_in(v12),
    .yin({{17{y12[18]}}, y12}), .xin({{17{x12[18]}}, x12}),
    .vld_out(av[3]), .ang(aa[3])
  );

  // p13: angle differences and base angle in Q24
  logic               v13;
  logic signed [28:0] el13, sh13, bs13;
  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else begin
      v13 <= av[0] && av[1] && av[2] && av[3];
    end
  end
  always_ff @(posedge clk) begin
    el13 <= {aa[0][AW-1], aa[0]} - {apik_pkg::Q24_PI[AW-1], apik_pkg::Q24_PI};
    sh13 <= {aa[2][AW-1], aa[2]} - {aa[1][AW-1], aa[1]};
    bs13 <= {aa[3][AW-1], aa[3]};
  end

  // round half away from zero to Q16, then clamp
  function automatic logic signed [22:0] rnd_clamp(input logic signed [28:0] v,
                                                   input logic signed [22:0] lo,
                                                   input logic signed [22:0] hi);
    logic [28:0]        mag;
    logic [20:0]        rm;
    logic signed [22:0] r;
    mag = v[28] ? 29'(-v) : 29'(v);
    rm  = 21'((mag + 29'd128) >> 8);
    r   = v[28] ? -$signed({2'b0, rm}) : $signed({2'b0, rm});
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic signed [22:0] bs_r, sh_r, el_r;
  assign bs_r = rnd_clamp(bs13, -23'sd205887, 23'sd205887);
  assign sh_r = rnd_clamp(sh13, -23'sd308831, 23'sd102944);
  assign el_r = rnd_clamp(el13, -23'sd205887, 23'sd0);

  // p14: result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v13;
    end
  end
  always_ff @(posedge clk) begin
    base_angle     <= bs_r[18:0];
    shoulder_angle <= sh_r[19:0];
    elbow_angle    <= el_r[18:0];
  end

`ifndef SYNTHESIS
  a_sqrt_align: assert property (@(posedge clk) disable iff (rst) sqa_v == sqb_v)
    else $error("square root pipelines out of step");
  a_atan_align: assert property (@(posedge clk) disable iff (rst)
    (av[0] == av[1]) && (av[1] == av[2]) && (av[2] == av[3]))
    else $error("atan2 pipelines out of step");
  a_reach_min: assert property (@(posedge clk) disable iff (rst)
    v5 |-> $past(d4) >= 17'(apik_pkg::REACH_MIN))
    else $error("reach below lower bound");
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    v8 |-> (c8 <= 18'sd65536) && (c8 >= -18'sd65536))
    else $error("cosine outside unit range");
  a_elbow_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> (elbow_angle[18] || elbow_angle == 19'sd0))
    else $error("elbow angle positive");
`endif

endmodule
